// ===== hdl/ccs_pkg.sv =====
// ----------------------------------------------------------------------------
// ccs_pkg: shared types and constants of the comment stripper
// Character codes, word formats of the item and result queues, and helpers
// that build result words.
// ----------------------------------------------------------------------------
package ccs_pkg;

	// Longest raw string delimiter and width of the line counter
	localparam int MAX_DELIM  = 16;
	localparam int LINE_BITS  = 24;
	localparam int OUT_LINE_W = 24;

	// Look-back window over raw input: delimiter plus paren; the closing quote is the current word
	localparam int WIN_LEN = MAX_DELIM + 1;
	localparam int DLEN_W  = $clog2(MAX_DELIM + 1);
	localparam int BODY_MAX = MAX_DELIM + 2;
	localparam int BODY_W   = $clog2(BODY_MAX + 1);

	// Queue sizes (powers of two)
	localparam int IQ_DEPTH = 2;
	localparam int IQ_PTR_W = $clog2(IQ_DEPTH);
	localparam int IQ_CNT_W = $clog2(IQ_DEPTH + 1);
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	// Character codes
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_R      = 8'h52;
	localparam logic [7:0] CH_LOW_U  = 8'h75;
	localparam logic [7:0] CH_UP_U   = 8'h55;
	localparam logic [7:0] CH_L      = 8'h4C;
	localparam logic [7:0] CH_8      = 8'h38;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_BLOCK = 2'd0,
		ERR_DELIM = 2'd1,
		ERR_RAW   = 2'd2,
		ERR_LIT   = 2'd3
	} err_t;

	// Classified input word
	typedef struct packed {
		logic       eof;
		logic [7:0] data;
		logic       ident;
		logic       bad_delim;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} iq_out_t;

	// Result word
	typedef struct packed {
		kind_t                 kind;
		logic [7:0]            data;
		err_t                  code;
		logic [OUT_LINE_W-1:0] line;
		logic                  last;
	} res_t;

	// Up to two result words written per cycle
	typedef struct packed {
		logic v0;
		logic v1;
		res_t r0;
		res_t r1;
	} oq_wr_t;

	typedef struct packed {
		logic                room;
		logic [OQ_CNT_W-1:0] count;
	} oq_stat_t;

	function automatic logic [OUT_LINE_W-1:0] sat_line(input logic [LINE_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		if (w > 32'(OUT_LINE_W'('1)))
			return '1;
		return w[OUT_LINE_W-1:0];
	endfunction

	function automatic res_t byte_res(input logic [7:0] b);
		res_t r;
		r      = '0;
		r.kind = KIND_BYTE;
		r.data = b;
		return r;
	endfunction

	function automatic res_t done_res();
		res_t r;
		r      = '0;
		r.kind = KIND_DONE;
		return r;
	endfunction

	function automatic res_t err_res(input err_t c, input logic [LINE_BITS-1:0] ln);
		res_t r;
		r      = '0;
		r.kind = KIND_ERROR;
		r.code = c;
		r.line = sat_line(ln);
		return r;
	endfunction

endpackage

// ===== hdl/c_comment_stripper.sv =====
// Order: a pushed word is registered in the input queue; the scanner takes it once
//   the result queue has room and registers its result words there, and empty falls.
// Throughput: one input word per cycle while the result queue has room; a word
//   that yields two results takes two pops to drain at the result side.
// Reset: arst_n clears both queues and the scanner state at once; no clearing
//   pass. The delimiter store holds garbage until a raw string writes it.
// ----------------------------------------------------------------------------
// c_comment_stripper: streaming C/C++ comment removal
// Front tags incoming source words and queues them, the scanner strips
// comments and tracks literals and raw strings, and a result queue buffers
// up to two result words per scanned word.
// ----------------------------------------------------------------------------
module c_comment_stripper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        action,
	input  logic [7:0]  in_byte,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  result_kind,
	output logic [7:0]  out_byte,
	output logic [1:0]  error_code,
	output logic [23:0] error_line,
	output logic        last_of_run
);
	import ccs_pkg::*;

	iq_out_t  iq;
	logic     take;
	oq_wr_t   oq_wr;
	oq_stat_t oq_stat;
	res_t     head;

	// Accept and classify source words
	ccs_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.action  (action),
		.in_byte (in_byte),
		.take    (take),
		.iq      (iq)
	);

	// Scan one word per cycle; stall while the result queue lacks room for two
	ccs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.iq     (iq),
		.take   (take),
		.oq     (oq_stat),
		.wr     (oq_wr)
	);

	// Hold result words until popped
	ccs_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (oq_wr),
		.pop    (pop),
		.empty  (empty),
		.head   (head),
		.stat   (oq_stat)
	);

	assign result_kind = head.kind;
	assign out_byte    = head.data;
	assign error_code  = head.code;
	assign error_line  = head.line;
	assign last_of_run = head.last;

	// Finish and error words always close their run
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (result_kind == KIND_DONE || result_kind == KIND_ERROR)) |-> last_of_run)
		else $error("finish or error word without last_of_run");

	// Result queue never overfills
	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		oq_stat.count <= OQ_CNT_W'(OQ_DEPTH))
		else $error("result queue overflow");

	// Scanner advances only with room for two result words
	a_take_room: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> oq_stat.room)
		else $error("scanner advanced without result queue room");

	// Input queue fills only after an accepted push
	a_full_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && !full))
		else $error("input queue filled without a push");

endmodule

// ===== hdl/ccs_front.sv =====
// ----------------------------------------------------------------------------
// ccs_front: input side of the comment stripper
// Accepts source words, tags identifier and bad-delimiter characters, and
// holds them in a short queue for the scanner.
// ----------------------------------------------------------------------------
module ccs_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic             action,
	input  logic [7:0]       in_byte,
	input  logic             take,
	output ccs_pkg::iq_out_t iq
);
	import ccs_pkg::*;

	item_t               mem_q [IQ_DEPTH];
	logic [IQ_PTR_W-1:0] wr_ptr_q;
	logic [IQ_PTR_W-1:0] rd_ptr_q;
	logic [IQ_CNT_W-1:0] cnt_q;
	logic                do_push;
	logic                do_pop;
	item_t               cls;

	function automatic logic is_ident(input logic [7:0] b);
		return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h7A) ||
			(b >= 8'h41 && b <= 8'h5A) || b == CH_UNDER;
	endfunction

	always_comb begin
		cls.eof       = action;
		cls.data      = in_byte;
		cls.ident     = is_ident(in_byte);
		cls.bad_delim = in_byte == CH_RPAREN || in_byte == CH_BSLASH ||
			in_byte == CH_SPACE || in_byte == CH_TAB || in_byte == CH_NL ||
			in_byte == CH_VT || in_byte == CH_FF || in_byte == CH_CR;
	end

	assign full     = cnt_q == IQ_CNT_W'(IQ_DEPTH);
	assign do_push  = push && !full;
	assign iq.valid = cnt_q != '0;
	assign iq.item  = mem_q[rd_ptr_q];
	assign do_pop   = take && iq.valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + IQ_PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + IQ_PTR_W'(1);
			cnt_q <= cnt_q + IQ_CNT_W'(do_push) - IQ_CNT_W'(do_pop);
		end
	end

endmodule

// ===== hdl/ccs_back.sv =====
// ----------------------------------------------------------------------------
// ccs_back: scanner of the comment stripper
// Runs the comment, literal and raw string state machine on one word per cycle
// while the result queue has room, and writes up to two result words into it.
// ----------------------------------------------------------------------------
module ccs_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ccs_pkg::iq_out_t  iq,
	output logic              take,
	input  ccs_pkg::oq_stat_t oq,
	output ccs_pkg::oq_wr_t   wr
);
	import ccs_pkg::*;

	typedef enum logic [8:0] {
		M_NORMAL    = 9'b000000001,
		M_SLASH     = 9'b000000010,
		M_LINE      = 9'b000000100,
		M_BLOCK     = 9'b000001000,
		M_LIT       = 9'b000010000,
		M_LIT_ESC   = 9'b000100000,
		M_RAW_DELIM = 9'b001000000,
		M_RAW_BODY  = 9'b010000000,
		M_HALT      = 9'b100000000
	} mode_t;

	mode_t                mode_q, mode_d;
	logic                 star_q, star_d;
	logic                 dbl_q, dbl_d;
	logic [LINE_BITS-1:0] line_q, line_d;
	logic [LINE_BITS-1:0] open_q, open_d;
	logic [2:0]           run_q, run_d;
	logic [7:0]           first_q, first_d;
	logic [7:0]           second_q, second_d;
	logic [7:0]           prev_q, prev_d;
	logic [DLEN_W-1:0]    dlen_q, dlen_d;
	logic [BODY_W-1:0]    body_q, body_d;
	logic [7:0]           win_q [WIN_LEN];
	logic [7:0]           dsh_q [MAX_DELIM];
	logic                 dsh_we;

	logic                 fire;
	item_t                it;
	logic [7:0]           b;
	logic                 raw_ok;
	logic                 use_norm;
	logic                 norm_second;
	logic                 delim_match;
	logic                 raw_close;
	logic [BODY_W-1:0]    body_inc;
	logic [7:0]           quote_ch;
	res_t                 nres;

	assign fire = iq.valid && oq.room;
	assign take = fire;
	assign it   = iq.item;
	assign b    = it.data;

	// Raw prefix: the run ends in R, and holds none, u, U, L or u8 before it
	always_comb begin
		raw_ok = 1'b0;
		if (prev_q == CH_R) begin
			case (run_q)
				3'd1: raw_ok = 1'b1;
				3'd2: raw_ok = first_q == CH_LOW_U || first_q == CH_UP_U || first_q == CH_L;
				3'd3: raw_ok = first_q == CH_LOW_U && second_q == CH_8;
				default: raw_ok = 1'b0;
			endcase
		end
	end

	// Closing match against the window before this word shifts in
	always_comb begin
		delim_match = 1'b1;
		for (int j = 0; j < MAX_DELIM; j++)
			delim_match = delim_match && ((DLEN_W'(j) >= dlen_q) || (win_q[j] == dsh_q[j]));
	end

	assign body_inc  = (body_q < BODY_W'(BODY_MAX)) ? body_q + BODY_W'(1) : body_q;
	assign raw_close = b == CH_DQUOTE && win_q[dlen_q] == CH_RPAREN && delim_match &&
		body_inc >= BODY_W'(dlen_q) + BODY_W'(2);
	assign quote_ch  = dbl_q ? CH_DQUOTE : CH_SQUOTE;
	assign nres      = byte_res(b);

	always_comb begin
		mode_d      = mode_q;
		star_d      = star_q;
		dbl_d       = dbl_q;
		line_d      = line_q;
		open_d      = open_q;
		run_d       = run_q;
		first_d     = first_q;
		second_d    = second_q;
		prev_d      = prev_q;
		dlen_d      = dlen_q;
		body_d      = body_q;
		dsh_we      = 1'b0;
		use_norm    = 1'b0;
		norm_second = 1'b0;
		wr          = '0;

		if (it.eof) begin
			case (mode_q)
				M_SLASH: begin
					wr.v0 = 1'b1;
					wr.r0 = byte_res(CH_SLASH);
					wr.v1 = 1'b1;
					wr.r1 = done_res();
				end
				M_NORMAL, M_LINE: begin
					wr.v0 = 1'b1;
					wr.r0 = done_res();
				end
				M_BLOCK: begin
					wr.v0 = 1'b1;
					wr.r0 = err_res(ERR_BLOCK, open_q);
				end
				M_RAW_DELIM: begin
					wr.v0 = 1'b1;
					wr.r0 = err_res(ERR_DELIM, open_q);
				end
				M_RAW_BODY: begin
					wr.v0 = 1'b1;
					wr.r0 = err_res(ERR_RAW, open_q);
				end
				M_LIT, M_LIT_ESC: begin
					wr.v0 = 1'b1;
					wr.r0 = err_res(ERR_LIT, open_q);
				end
				default: ;
			endcase
			// Back to reset state for the next stream
			mode_d   = M_NORMAL;
			star_d   = 1'b0;
			dbl_d    = 1'b0;
			line_d   = LINE_BITS'(1);
			open_d   = LINE_BITS'(1);
			run_d    = '0;
			first_d  = '0;
			second_d = '0;
			prev_d   = '0;
			dlen_d   = '0;
			body_d   = '0;
		end else begin
			case (mode_q)
				M_NORMAL: use_norm = 1'b1;
				M_SLASH: begin
					if (b == CH_SLASH) begin
						mode_d = M_LINE;
					end else if (b == CH_STAR) begin
						open_d = line_q;
						star_d = 1'b0;
						mode_d = M_BLOCK;
					end else begin
						wr.v0       = 1'b1;
						wr.r0       = byte_res(CH_SLASH);
						use_norm    = 1'b1;
						norm_second = 1'b1;
					end
				end
				M_LINE: begin
					if (b == CH_NL) begin
						mode_d = M_NORMAL;
						wr.v0  = 1'b1;
						wr.r0  = nres;
					end
				end
				M_BLOCK: begin
					if (star_q && b == CH_SLASH) begin
						mode_d = M_NORMAL;
						wr.v0  = 1'b1;
						wr.r0  = byte_res(CH_SPACE);
					end else begin
						star_d = b == CH_STAR;
					end
				end
				M_LIT: begin
					if (b == CH_BSLASH) begin
						wr.v0  = 1'b1;
						wr.r0  = nres;
						mode_d = M_LIT_ESC;
					end else if (b == quote_ch) begin
						wr.v0  = 1'b1;
						wr.r0  = nres;
						mode_d = M_NORMAL;
					end else if (b == CH_NL) begin
						wr.v0  = 1'b1;
						wr.r0  = err_res(ERR_LIT, open_q);
						mode_d = M_HALT;
					end else begin
						wr.v0 = 1'b1;
						wr.r0 = nres;
					end
				end
				M_LIT_ESC: begin
					wr.v0  = 1'b1;
					wr.r0  = nres;
					mode_d = M_LIT;
				end
				M_RAW_DELIM: begin
					if (b == CH_LPAREN) begin
						body_d = '0;
						mode_d = M_RAW_BODY;
						wr.v0  = 1'b1;
						wr.r0  = nres;
					end else if (it.bad_delim || dlen_q >= DLEN_W'(MAX_DELIM)) begin
						wr.v0  = 1'b1;
						wr.r0  = err_res(ERR_DELIM, open_q);
						mode_d = M_HALT;
					end else begin
						dsh_we = 1'b1;
						dlen_d = dlen_q + DLEN_W'(1);
						wr.v0  = 1'b1;
						wr.r0  = nres;
					end
				end
				M_RAW_BODY: begin
					wr.v0  = 1'b1;
					wr.r0  = nres;
					body_d = body_inc;
					if (raw_close)
						mode_d = M_NORMAL;
				end
				default: ;
			endcase

			// Plain text handling, also for the word after a lone slash
			if (use_norm) begin
				if (b == CH_SLASH) begin
					mode_d = M_SLASH;
				end else begin
					if (b == CH_DQUOTE && raw_ok) begin
						open_d = line_q;
						dlen_d = '0;
						mode_d = M_RAW_DELIM;
					end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
						open_d = line_q;
						dbl_d  = b == CH_DQUOTE;
						mode_d = M_LIT;
					end else begin
						mode_d = M_NORMAL;
					end
					if (norm_second) begin
						wr.v1 = 1'b1;
						wr.r1 = nres;
					end else begin
						wr.v0 = 1'b1;
						wr.r0 = nres;
					end
				end
			end

			// Track lines and the identifier run ahead of a possible raw prefix
			if (b == CH_NL && line_q != '1)
				line_d = line_q + LINE_BITS'(1);
			if (it.ident) begin
				if (run_q == 3'd0)
					first_d = b;
				else if (run_q == 3'd1)
					second_d = b;
				if (run_q != 3'd7)
					run_d = run_q + 3'd1;
			end else begin
				run_d = '0;
			end
			prev_d = b;
		end

		if (wr.v1)
			wr.r1.last = 1'b1;
		else
			wr.r0.last = wr.v0;

		if (!fire) begin
			wr.v0 = 1'b0;
			wr.v1 = 1'b0;
		end
	end

	// Window and delimiter shift lines, newest first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WIN_LEN; k++)
				win_q[k] <= '0;
		end else if (fire && !it.eof) begin
			win_q[0] <= b;
			for (int k = 1; k < WIN_LEN; k++)
				win_q[k] <= win_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (fire && dsh_we) begin
			dsh_q[0] <= b;
			for (int k = 1; k < MAX_DELIM; k++)
				dsh_q[k] <= dsh_q[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_NORMAL;
			star_q   <= 1'b0;
			dbl_q    <= 1'b0;
			line_q   <= LINE_BITS'(1);
			open_q   <= LINE_BITS'(1);
			run_q    <= '0;
			first_q  <= '0;
			second_q <= '0;
			prev_q   <= '0;
			dlen_q   <= '0;
			body_q   <= '0;
		end else if (fire) begin
			mode_q   <= mode_d;
			star_q   <= star_d;
			dbl_q    <= dbl_d;
			line_q   <= line_d;
			open_q   <= open_d;
			run_q    <= run_d;
			first_q  <= first_d;
			second_q <= second_d;
			prev_q   <= prev_d;
			dlen_q   <= dlen_d;
			body_q   <= body_d;
		end
	end

endmodule

// ===== hdl/ccs_outq.sv =====
// ----------------------------------------------------------------------------
// ccs_outq: result queue of the comment stripper
// Takes up to two result words a cycle and hands out the oldest one.
// ----------------------------------------------------------------------------
module ccs_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  ccs_pkg::oq_wr_t   wr,
	input  logic              pop,
	output logic              empty,
	output ccs_pkg::res_t     head,
	output ccs_pkg::oq_stat_t stat
);
	import ccs_pkg::*;

	res_t                mem_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] wr_ptr_q;
	logic [OQ_PTR_W-1:0] wr_ptr1;
	logic [OQ_PTR_W-1:0] rd_ptr_q;
	logic [OQ_CNT_W-1:0] cnt_q;
	logic                do_pop;
	logic [1:0]          n_wr;

	assign empty      = cnt_q == '0;
	assign head       = mem_q[rd_ptr_q];
	assign do_pop     = pop && !empty;
	assign wr_ptr1    = wr_ptr_q + OQ_PTR_W'(1);
	assign n_wr       = 2'(wr.v0) + 2'(wr.v1);
	assign stat.room  = cnt_q <= OQ_CNT_W'(OQ_DEPTH - 2);
	assign stat.count = cnt_q;

	always_ff @(posedge clk) begin
		if (wr.v0)
			mem_q[wr_ptr_q] <= wr.r0;
		if (wr.v1)
			mem_q[wr_ptr1] <= wr.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OQ_PTR_W'(n_wr);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + OQ_PTR_W'(1);
			cnt_q <= cnt_q + OQ_CNT_W'(n_wr) - OQ_CNT_W'(do_pop);
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the streaming C/C++ comment stripper
// Feeds source words through the push/full queue port and drains result
// words through the empty/pop port. A short table of hand-written words opens
// the run, then random streams built from comments, literals, raw strings and
// noise follow under several idle patterns. Every result word is checked
// against an in-bench scanner model, or against the hand-typed result of a table row.
// ----------------------------------------------------------------------------
module tb;
	import ccs_pkg::*;

	localparam int WIN_DEPTH     = MAX_DELIM + 2;
	localparam int BODY_CAP      = MAX_DELIM + 2;
	localparam int WATCHDOG      = 2000;
	localparam int TAIL_CYCLES   = 8;
	localparam int PHASE_WORDS   = 90;
	localparam int SHOW_MISMATCH = 10;

	typedef enum logic [3:0] {
		SC_NORMAL,
		SC_SLASH,
		SC_LINE,
		SC_BLOCK,
		SC_LIT,
		SC_LIT_ESC,
		SC_RAW_DELIM,
		SC_RAW_BODY,
		SC_HALT
	} scan_t;

	// One source word as it goes onto the input port
	typedef struct packed {
		logic       eof;
		logic [7:0] b;
	} word_t;

	// A row of the opening table: the word, and the result typed in by hand
	typedef struct {
		word_t w;
		bit    typed;
		res_t  want;
	} dir_row_t;

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        push    = 1'b0;
	logic        action  = 1'b0;
	logic [7:0]  in_byte = 8'h00;
	logic        pop     = 1'b0;
	logic        full;
	logic        empty;
	logic [1:0]  result_kind;
	logic [7:0]  out_byte;
	logic [1:0]  error_code;
	logic [23:0] error_line;
	logic        last_of_run;

	c_comment_stripper u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.action      (action),
		.in_byte     (in_byte),
		.empty       (empty),
		.pop         (pop),
		.result_kind (result_kind),
		.out_byte    (out_byte),
		.error_code  (error_code),
		.error_line  (error_line),
		.last_of_run (last_of_run)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// Scanner model state
	// ------------------------------------------------------------------
	scan_t        mode;
	logic         star;
	logic         dq;
	logic [23:0]  line_cnt;
	logic [23:0]  open_ln;
	logic [2:0]   id_len;
	logic [7:0]   id_c1;
	logic [7:0]   id_c2;
	logic [7:0]   prev_b;
	logic [7:0]   delim [MAX_DELIM];
	int           dlen;
	logic [7:0]   win [WIN_DEPTH];
	int           body_n;

	// Result words of the word being scanned, then the words still due
	res_t         pend_res [2];
	int           pend_n;
	res_t         due_words [$];

	// Stimulus bookkeeping
	dir_row_t     dir_tbl [$];
	word_t        src_q [$];
	bit           row_typed;
	res_t         row_want;
	int           send_idle  = 0;
	int           stall_pct  = 0;

	// Scoreboard counters
	int           err_count  = 0;
	int           words_in   = 0;
	int           words_out  = 0;
	int           n_done     = 0;
	int           n_fail     = 0;
	int           n_streams  = 0;
	int           quiet_cycles = 0;
	logic         moved;
	res_t         head;

	string IDC = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
	string DCH = "abcXYZ09_!#%&*+-.:;<=>?@[]^{|}~";

	task automatic reset_model();
		begin
			mode     = SC_NORMAL;
			star     = 1'b0;
			dq       = 1'b0;
			line_cnt = 24'd1;
			open_ln  = 24'd1;
			id_len   = 3'd0;
			id_c1    = 8'h00;
			id_c2    = 8'h00;
			prev_b   = 8'h00;
			dlen     = 0;
			body_n   = 0;
			for (int i = 0; i < MAX_DELIM; i++)
				delim[i] = 8'h00;
			for (int i = 0; i < WIN_DEPTH; i++)
				win[i] = 8'h00;
		end
	endtask

	// Code and line stay zero unless the word is an error
	task automatic emit(input kind_t k, input logic [7:0] d);
		begin
			if (pend_n < 2) begin
				pend_res[pend_n]      = '0;
				pend_res[pend_n].kind = k;
				pend_res[pend_n].data = d;
				pend_n++;
			end
		end
	endtask

	task automatic halt(input err_t c);
		begin
			if (pend_n < 2) begin
				pend_res[pend_n]      = '0;
				pend_res[pend_n].kind = KIND_ERROR;
				pend_res[pend_n].code = c;
				pend_res[pend_n].line = open_ln;
				pend_n++;
			end
			mode = SC_HALT;
		end
	endtask

	// Plain text: a slash waits for its partner, quotes open literals or raw strings
	task automatic normal_text(input logic [7:0] b);
		int plen;
		bit raw_ok;
		begin
			plen   = int'(id_len) - 1;
			raw_ok = 1'b0;
			if (prev_b == CH_R && id_len != 3'd0) begin
				if (plen == 0)
					raw_ok = 1'b1;
				else if (plen == 1)
					raw_ok = (id_c1 == CH_LOW_U) || (id_c1 == CH_UP_U) || (id_c1 == CH_L);
				else if (plen == 2)
					raw_ok = (id_c1 == CH_LOW_U) && (id_c2 == CH_8);
			end
			if (b == CH_SLASH) begin
				mode = SC_SLASH;
			end else if (b == CH_DQUOTE && raw_ok) begin
				open_ln = line_cnt;
				dlen    = 0;
				mode    = SC_RAW_DELIM;
				emit(KIND_BYTE, b);
			end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
				open_ln = line_cnt;
				dq      = (b == CH_DQUOTE);
				mode    = SC_LIT;
				emit(KIND_BYTE, b);
			end else begin
				emit(KIND_BYTE, b);
			end
		end
	endtask

	// Scan one accepted word; leaves its result words in pend_res
	task automatic scan_word(input logic eof, input logic [7:0] b);
		logic [7:0] q;
		bit         closed;
		bit         ident;
		begin
			pend_n = 0;
			if (eof) begin
				case (mode)
					SC_SLASH: begin
						emit(KIND_BYTE, CH_SLASH);
						emit(KIND_DONE, 8'h00);
					end
					SC_NORMAL, SC_LINE: emit(KIND_DONE, 8'h00);
					SC_BLOCK:           halt(ERR_BLOCK);
					SC_RAW_DELIM:       halt(ERR_DELIM);
					SC_RAW_BODY:        halt(ERR_RAW);
					SC_LIT, SC_LIT_ESC: halt(ERR_LIT);
					default: ;
				endcase
				reset_model();
			end else begin
				for (int i = WIN_DEPTH - 1; i > 0; i--)
					win[i] = win[i-1];
				win[0] = b;
				case (mode)
					SC_NORMAL: normal_text(b);
					SC_SLASH: begin
						if (b == CH_SLASH) begin
							mode = SC_LINE;
						end else if (b == CH_STAR) begin
							open_ln = line_cnt;
							star    = 1'b0;
							mode    = SC_BLOCK;
						end else begin
							emit(KIND_BYTE, CH_SLASH);
							mode = SC_NORMAL;
							normal_text(b);
						end
					end
					SC_LINE: begin
						if (b == CH_NL) begin
							mode = SC_NORMAL;
							emit(KIND_BYTE, b);
						end
					end
					SC_BLOCK: begin
						if (star && b == CH_SLASH) begin
							mode = SC_NORMAL;
							emit(KIND_BYTE, CH_SPACE);
						end else begin
							star = (b == CH_STAR);
						end
					end
					SC_LIT: begin
						q = dq ? CH_DQUOTE : CH_SQUOTE;
						if (b == CH_BSLASH) begin
							emit(KIND_BYTE, b);
							mode = SC_LIT_ESC;
						end else if (b == q) begin
							emit(KIND_BYTE, b);
							mode = SC_NORMAL;
						end else if (b == CH_NL) begin
							halt(ERR_LIT);
						end else begin
							emit(KIND_BYTE, b);
						end
					end
					SC_LIT_ESC: begin
						emit(KIND_BYTE, b);
						mode = SC_LIT;
					end
					SC_RAW_DELIM: begin
						if (b == CH_LPAREN) begin
							body_n = 0;
							mode   = SC_RAW_BODY;
							emit(KIND_BYTE, b);
						end else if (b == CH_RPAREN || b == CH_BSLASH || b == CH_SPACE ||
							b == CH_TAB || b == CH_NL || b == CH_VT || b == CH_FF ||
							b == CH_CR || dlen >= MAX_DELIM) begin
							halt(ERR_DELIM);
						end else begin
							delim[dlen] = b;
							dlen++;
							emit(KIND_BYTE, b);
						end
					end
					SC_RAW_BODY: begin
						emit(KIND_BYTE, b);
						if (body_n < BODY_CAP)
							body_n++;
						// Close on quote, delimiter reversed in the window, then paren
						closed = (body_n >= dlen + 2) && (win[0] == CH_DQUOTE) &&
							(win[dlen+1] == CH_RPAREN);
						for (int i = 0; i < dlen; i++)
							if (win[dlen-i] != delim[i])
								closed = 1'b0;
						if (closed)
							mode = SC_NORMAL;
					end
					default: ;
				endcase
				// Track lines and the identifier run that precedes a raw quote
				if (b == CH_NL && line_cnt != '1)
					line_cnt++;
				ident = (b >= "0" && b <= "9") || (b >= "a" && b <= "z") ||
					(b >= "A" && b <= "Z") || b == CH_UNDER;
				if (ident) begin
					if (id_len == 3'd0)
						id_c1 = b;
					else if (id_len == 3'd1)
						id_c2 = b;
					if (id_len != 3'd7)
						id_len++;
				end else begin
					id_len = 3'd0;
				end
				prev_b = b;
			end
			if (pend_n > 0)
				pend_res[pend_n-1].last = 1'b1;
		end
	endtask

	// ------------------------------------------------------------------
	// Monitor: sample both ports on the rising edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			moved = 1'b0;
			// Check the result word first; it always stems from an older word
			if (pop && empty === 1'b0) begin
				moved = 1'b1;
				if (due_words.size() == 0) begin
					err_count++;
					if (err_count <= SHOW_MISMATCH)
						$display("unexpected result word: kind=%0d byte=%02h code=%0d line=%0d last=%0b",
							result_kind, out_byte, error_code, error_line, last_of_run);
				end else begin
					head = due_words.pop_front();
					words_out++;
					if (head.kind == KIND_DONE)
						n_done++;
					if (head.kind == KIND_ERROR)
						n_fail++;
					if (result_kind !== head.kind || out_byte !== head.data ||
						error_code !== head.code || error_line !== head.line ||
						last_of_run !== head.last) begin
						err_count++;
						if (err_count <= SHOW_MISMATCH)
							$display("mismatch on result %0d: want kind=%0d byte=%02h code=%0d line=%0d last=%0b, got kind=%0d byte=%02h code=%0d line=%0d last=%0b",
								words_out, head.kind, head.data, head.code, head.line, head.last,
								result_kind, out_byte, error_code, error_line, last_of_run);
					end
				end
			end
			// Scan the accepted source word; table rows carry a hand-typed result
			if (push && full === 1'b0) begin
				moved = 1'b1;
				words_in++;
				scan_word(action, in_byte);
				if (row_typed) begin
					due_words.push_back(row_want);
				end else begin
					for (int i = 0; i < pend_n; i++)
						due_words.push_back(pend_res[i]);
				end
			end
			// Watchdog: give up when no word moves on either port for too long
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG) begin
				$display("watchdog: no word moved for %0d cycles, %0d results still due",
					WATCHDOG, due_words.size());
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Receiver: stall at random with the current percentage
	always @(negedge clk)
		pop <= ($urandom_range(0, 99) >= stall_pct);

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic logic [7:0] pick(input string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	task automatic put_b(input logic [7:0] b);
		word_t w;
		begin
			w.eof = 1'b0;
			w.b   = b;
			src_q.push_back(w);
		end
	endtask

	// Entered and left just after a falling edge; hold the word until taken
	task automatic send_word(input word_t w, input bit typed, input res_t want);
		begin
			while ($urandom_range(0, 99) < send_idle) begin
				push <= 1'b0;
				@(negedge clk);
			end
			push      <= 1'b1;
			action    <= w.eof;
			in_byte   <= w.b;
			row_typed = typed;
			row_want  = want;
			@(posedge clk);
			while (full !== 1'b0)
				@(posedge clk);
			@(negedge clk);
		end
	endtask

	// Drop push and hold off until every due result word has been popped
	task automatic wait_drained();
		begin
			push <= 1'b0;
			do
				@(negedge clk);
			while (due_words.size() != 0);
		end
	endtask

	task automatic add_row(input logic eof, input logic [7:0] b, input bit typed,
		input kind_t k, input logic [7:0] d, input err_t c, input logic [23:0] ln);
		dir_row_t r;
		begin
			r.w.eof     = eof;
			r.w.b       = b;
			r.typed     = typed;
			r.want      = '0;
			r.want.kind = k;
			r.want.data = d;
			r.want.code = c;
			r.want.line = ln;
			r.want.last = 1'b1;
			dir_tbl.push_back(r);
		end
	endtask

	// Build one stream of tokens into src_q, closed by an end-of-file word
	task automatic gen_stream();
		int         ntok;
		int         dl;
		int         start;
		int         keep;
		logic [7:0] dbuf [MAX_DELIM + 1];
		word_t      w;
		begin
			start = src_q.size();
			ntok  = $urandom_range(2, 10);
			repeat (ntok) begin
				case ($urandom_range(0, 11))
					0, 1: begin
						repeat ($urandom_range(1, 5))
							put_b(pick(IDC));
						if ($urandom_range(0, 3) == 0)
							put_b(CH_NL);
						else
							put_b(pick(" ;=+"));
					end
					2: begin
						put_b(CH_SLASH);
						put_b(CH_SLASH);
						repeat ($urandom_range(0, 6))
							put_b(8'($urandom_range(0, 255)));
						put_b(CH_NL);
					end
					3: begin
						put_b(CH_SLASH);
						put_b(CH_STAR);
						repeat ($urandom_range(0, 6))
							put_b(($urandom_range(0, 4) == 0) ? CH_NL : pick("**/ a"));
						put_b(CH_STAR);
						put_b(CH_SLASH);
					end
					4: begin
						put_b(CH_DQUOTE);
						repeat ($urandom_range(0, 6)) begin
							if ($urandom_range(0, 3) == 0) begin
								put_b(CH_BSLASH);
								put_b(pick("\"\\n'"));
							end else begin
								put_b(pick("ab /*'"));
							end
						end
						put_b(CH_DQUOTE);
					end
					5: begin
						put_b(CH_SQUOTE);
						if ($urandom_range(0, 1) == 0)
							put_b(CH_BSLASH);
						put_b(pick("a'\"/n"));
						put_b(CH_SQUOTE);
					end
					6, 7, 8: begin
						// Raw string: fresh identifier run, prefix, R and quote
						put_b(CH_SPACE);
						case ($urandom_range(0, 6))
							0: ;
							1: put_b(CH_LOW_U);
							2: put_b(CH_UP_U);
							3: put_b(CH_L);
							4: begin put_b(CH_LOW_U); put_b(CH_8); end
							5: begin put_b(CH_LOW_U); put_b(CH_LOW_U); end
							default: put_b("x");
						endcase
						put_b(CH_R);
						put_b(CH_DQUOTE);
						case ($urandom_range(0, 9))
							0, 1, 2, 3, 4, 5: dl = $urandom_range(0, 4);
							6, 7:             dl = $urandom_range(5, MAX_DELIM);
							8:                dl = MAX_DELIM;
							default:          dl = MAX_DELIM + 1;
						endcase
						for (int i = 0; i < dl; i++) begin
							dbuf[i] = pick(DCH);
							put_b(dbuf[i]);
						end
						// Now and then a byte that a delimiter may not hold
						if ($urandom_range(0, 9) == 0) begin
							case ($urandom_range(0, 7))
								0: put_b(CH_RPAREN);
								1: put_b(CH_BSLASH);
								2: put_b(CH_SPACE);
								3: put_b(CH_TAB);
								4: put_b(CH_NL);
								5: put_b(CH_VT);
								6: put_b(CH_FF);
								default: put_b(CH_CR);
							endcase
						end
						put_b(CH_LPAREN);
						// Body with near misses of the closing sequence
						repeat ($urandom_range(0, 8)) begin
							case ($urandom_range(0, 3))
								0: put_b(CH_RPAREN);
								1: put_b(CH_DQUOTE);
								2: put_b((dl > 0) ? dbuf[$urandom_range(0, dl - 1)] : CH_NL);
								default: put_b(pick("ab/*"));
							endcase
						end
						put_b(CH_RPAREN);
						for (int i = 0; i < dl; i++)
							put_b(dbuf[i]);
						put_b(CH_DQUOTE);
					end
					9: begin
						put_b(CH_SLASH);
						put_b(pick(" a=("));
					end
					10: put_b(8'($urandom_range(0, 255)));
					default: put_b(CH_NL);
				endcase
			end
			// Cut some streams short so the end of file lands inside a construct
			if ($urandom_range(0, 7) == 0 && src_q.size() > start) begin
				keep = $urandom_range(start, src_q.size() - 1);
				while (src_q.size() > keep)
					src_q.delete(src_q.size() - 1);
			end
			w.eof = 1'b1;
			w.b   = 8'($urandom_range(0, 255));
			src_q.push_back(w);
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : main
		int   phase_words;
		res_t no_want;
		begin
			no_want   = '0;
			row_typed = 1'b0;
			row_want  = '0;
			reset_model();

			// Opening table; typed results only where they are obvious
			add_row(1'b1, 8'h00,     1'b1, KIND_DONE,  8'h00,    ERR_BLOCK, 24'd0);
			add_row(1'b0, 8'h00,     1'b1, KIND_BYTE,  8'h00,    ERR_BLOCK, 24'd0);
			add_row(1'b0, 8'hFF,     1'b1, KIND_BYTE,  8'hFF,    ERR_BLOCK, 24'd0);
			// line comment: drop its body, keep the newline
			add_row(1'b0, CH_SLASH,  1'b0, KIND_BYTE,  8'h00,    ERR_BLOCK, 24'd0);
			add_row(1'b0, CH_SLASH,  1'b0, KIND_BYTE,  8'h00,    ERR_BLOCK, 24'd0);
			add_row(1'b0, "x",       1'b0, KIND_BYTE,  8'h00,    ERR_BLOCK, 24'd0);
			add_row(1'b0, CH_NL,     1'b1, KIND_BYTE,  CH_NL,    ERR_BLOCK, 24'd0);
			// block comment with a doubled star collapses to one space
			add_row(1'b0, CH_SLASH,  1'b0, KIND_BYTE,  8'h00,    ERR_BLOCK, 24'd0);
			add_row(1'b0, CH_STAR,   1'b0, KIND_BYTE,  8'h00,    ERR_BLOCK, 24'd0);
			add_row(1'b0, CH_STAR,   1'b0, KIND_BYTE,  8'h00,    ERR_BLOCK, 24'd0);
			add_row(1'b0, CH_SLASH,  1'b1, KIND_BYTE,  CH_SPACE, ERR_BLOCK, 24'd0);
			// lone slash before text gives two words
			add_row(1'b0, CH_SLASH,  1'b0, KIND_BYTE,  8'h00,    ERR_BLOCK, 24'd0);
			add_row(1'b0, "q",       1'b0, KIND_BYTE,  8'h00,    ERR_BLOCK, 24'd0);
			// string with an escaped quote
			add_row(1'b0, CH_DQUOTE, 1'b0, KIND_BYTE,  8'h00,    ERR_BLOCK, 24'd0);
			add_row(1'b0, CH_BSLASH, 1'b0, KIND_BYTE,  8'h00,    ERR_BLOCK, 24'd0);
			add_row(1'b0, CH_DQUOTE, 1'b0, KIND_BYTE,  8'h00,    ERR_BLOCK, 24'd0);
			add_row(1'b0, CH_DQUOTE, 1'b0, KIND_BYTE,  8'h00,    ERR_BLOCK, 24'd0);
			// raw string with an empty delimiter
			add_row(1'b0, CH_R,      1'b0, KIND_BYTE,  8'h00,    ERR_BLOCK, 24'd0);
			add_row(1'b0, CH_DQUOTE, 1'b0, KIND_BYTE,  8'h00,    ERR_BLOCK, 24'd0);
			add_row(1'b0, CH_LPAREN, 1'b0, KIND_BYTE,  8'h00,    ERR_BLOCK, 24'd0);
			add_row(1'b0, CH_RPAREN, 1'b0, KIND_BYTE,  8'h00,    ERR_BLOCK, 24'd0);
			add_row(1'b0, CH_DQUOTE, 1'b0, KIND_BYTE,  8'h00,    ERR_BLOCK, 24'd0);
			// pending slash at end of file
			add_row(1'b0, CH_SLASH,  1'b0, KIND_BYTE,  8'h00,    ERR_BLOCK, 24'd0);
			add_row(1'b1, 8'hA5,     1'b0, KIND_BYTE,  8'h00,    ERR_BLOCK, 24'd0);
			// newline in a char literal; then bytes are ignored until end of file
			add_row(1'b0, CH_SQUOTE, 1'b0, KIND_BYTE,  8'h00,    ERR_BLOCK, 24'd0);
			add_row(1'b0, CH_NL,     1'b1, KIND_ERROR, 8'h00,    ERR_LIT,   24'd1);
			add_row(1'b0, "z",       1'b0, KIND_BYTE,  8'h00,    ERR_BLOCK, 24'd0);
			add_row(1'b1, 8'h5A,     1'b0, KIND_BYTE,  8'h00,    ERR_BLOCK, 24'd0);
			// close paren inside a raw delimiter
			add_row(1'b0, CH_R,      1'b0, KIND_BYTE,  8'h00,    ERR_BLOCK, 24'd0);
			add_row(1'b0, CH_DQUOTE, 1'b0, KIND_BYTE,  8'h00,    ERR_BLOCK, 24'd0);
			add_row(1'b0, CH_RPAREN, 1'b1, KIND_ERROR, 8'h00,    ERR_DELIM, 24'd1);
			add_row(1'b1, 8'h00,     1'b0, KIND_BYTE,  8'h00,    ERR_BLOCK, 24'd0);
			// end of file inside a block comment, then inside a raw body
			add_row(1'b0, CH_SLASH,  1'b0, KIND_BYTE,  8'h00,    ERR_BLOCK, 24'd0);
			add_row(1'b0, CH_STAR,   1'b0, KIND_BYTE,  8'h00,    ERR_BLOCK, 24'd0);
			add_row(1'b1, 8'h00,     1'b1, KIND_ERROR, 8'h00,    ERR_BLOCK, 24'd1);
			add_row(1'b0, CH_R,      1'b0, KIND_BYTE,  8'h00,    ERR_BLOCK, 24'd0);
			add_row(1'b0, CH_DQUOTE, 1'b0, KIND_BYTE,  8'h00,    ERR_BLOCK, 24'd0);
			add_row(1'b0, CH_LPAREN, 1'b0, KIND_BYTE,  8'h00,    ERR_BLOCK, 24'd0);
			add_row(1'b1, 8'hFF,     1'b1, KIND_ERROR, 8'h00,    ERR_RAW,   24'd1);

			// Hold reset, then release it on a falling edge
			repeat (11) @(negedge clk);
			arst_n <= 1'b1;

			foreach (dir_tbl[i])
				send_word(dir_tbl[i].w, dir_tbl[i].typed, dir_tbl[i].want);
			wait_drained();

			// Random streams: free running, idle sender, stalling receiver, both
			for (int ph = 0; ph < 4; ph++) begin
				case (ph)
					0:       begin send_idle = 0;  stall_pct = 0;  end
					1:       begin send_idle = 67; stall_pct = 0;  end
					2:       begin send_idle = 0;  stall_pct = 67; end
					default: begin send_idle = 33; stall_pct = 33; end
				endcase
				phase_words = 0;
				while (phase_words < PHASE_WORDS) begin
					gen_stream();
					phase_words += src_q.size();
					n_streams++;
					while (src_q.size() != 0)
						send_word(src_q.pop_front(), 1'b0, no_want);
				end
				// Let everything drain before the idle pattern changes
				wait_drained();
			end

			repeat (TAIL_CYCLES) @(posedge clk);

			$display("run covered %0d source words (%0d random streams), %0d result words checked",
				words_in, n_streams, words_out);
			$display("  of which %0d clean finishes and %0d error reports", n_done, n_fail);
			if (err_count == 0)
				$display("DONE: 0 errors");
			else
				$display("DONE: errors detected");
			$finish;
		end
	end

endmodule

// ===== sim.f =====
hdl/ccs_pkg.sv
hdl/ccs_front.sv
hdl/ccs_back.sv
hdl/ccs_outq.sv
hdl/c_comment_stripper.sv
tb/tb.sv
